[hw/rtl/egas_pkg.sv]
// Shared types and constants for the epsilon-greedy arm selector.
// Holds the item structs, command and register codes, FSM states and
// the compare unit status. No dependencies.
package egas_pkg;

  localparam int SUM_BITS  = 48;  // per-arm reward sum, signed Q40.8
  localparam int HALF_BITS = 24;  // split point of the sum for the multiplier
  localparam int EPS_BITS  = 17;
  localparam int ACT_BITS  = 5;
  localparam int CFG_BITS  = 17;  // widest register

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CHOOSE = 1'b1;

  localparam logic REG_EPSILON = 1'b0;
  localparam logic REG_ACTIVE  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         arm_index;
    logic signed [15:0] reward_value;
    logic [15:0]        random_fraction;
    logic [3:0]         random_arm;
  } in_item_t;

  typedef struct packed {
    logic [3:0] chosen_arm;
    logic       explored;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_RD,
    ST_REC_WR,
    ST_CH_RD,
    ST_CH_LOAD,
    ST_CH_CMP
  } state_t;

  typedef struct packed {
    logic done;
    logic greater;
  } cmp_status_t;

endpackage

[hw/rtl/egas_ram.sv]
// Generic simple dual-port RAM: one write port, one read port,
// registered read data. No dependencies.
module egas_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/egas_table.sv]
// Per-arm count/sum table: one RAM plus a valid bit per arm so that
// reset clears the table at once. Depends on egas_ram.
module egas_table #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [DEPTH-1:0] valid;
  logic             rd_valid;
  logic [WIDTH-1:0] ram_q;

  egas_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  // never-written entry reads as zero count, zero sum
  assign rdata = rd_valid ? ram_q : '0;

endmodule

[hw/rtl/egas_cmp.sv]
// Sequential exact mean compare: a/b > c/d as a*d > c*b, built from
// four 25x(COUNT_BITS+1) signed products on one shared multiplier.
// Depends on egas_pkg.
module egas_cmp #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [egas_pkg::SUM_BITS-1:0] a,
  input  logic [COUNT_BITS-1:0]               b,
  input  logic signed [egas_pkg::SUM_BITS-1:0] c,
  input  logic [COUNT_BITS-1:0]               d,
  output egas_pkg::cmp_status_t               status
);

  localparam int MY   = COUNT_BITS + 1;
  localparam int MX   = egas_pkg::HALF_BITS + 1;
  localparam int PRW  = MX + MY;
  localparam int PW   = egas_pkg::SUM_BITS + MY;
  localparam int HB   = egas_pkg::HALF_BITS;
  localparam logic [2:0] LAST_STEP = 3'd5;

  logic                                 running;
  logic [2:0]                           step;
  logic signed [egas_pkg::SUM_BITS-1:0] a_q, c_q;
  logic [COUNT_BITS-1:0]                b_q, d_q;
  logic signed [MX-1:0]                 mul_x;
  logic signed [MY-1:0]                 mul_y;
  logic signed [PRW-1:0]                prod;
  logic signed [PW-1:0]                 acc1, acc2;

  // step 0: a_lo*d, 1: a_hi*d, 2: c_lo*b, 3: c_hi*b
  always_comb begin
    case (step)
      3'd1: begin
        mul_x = $signed({a_q[egas_pkg::SUM_BITS-1], a_q[egas_pkg::SUM_BITS-1:HB]});
        mul_y = $signed({1'b0, d_q});
      end
      3'd2: begin
        mul_x = $signed({1'b0, c_q[HB-1:0]});
        mul_y = $signed({1'b0, b_q});
      end
      3'd3: begin
        mul_x = $signed({c_q[egas_pkg::SUM_BITS-1], c_q[egas_pkg::SUM_BITS-1:HB]});
        mul_y = $signed({1'b0, b_q});
      end
      default: begin
        mul_x = $signed({1'b0, a_q[HB-1:0]});
        mul_y = $signed({1'b0, d_q});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
    end else if (start) begin
      running <= 1'b1;
      step    <= '0;
    end else if (running) begin
      step <= step + 3'd1;
      if (step == LAST_STEP) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      c_q <= c;
      d_q <= d;
    end
    prod <= PRW'(mul_x) * PRW'(mul_y);
    case (step)
      3'd1:    acc1 <= PW'(prod);
      3'd2:    acc1 <= acc1 + (PW'(prod) <<< HB);
      3'd3:    acc2 <= PW'(prod);
      3'd4:    acc2 <= acc2 + (PW'(prod) <<< HB);
      default: ;
    endcase
  end

  assign status.done    = running && (step == LAST_STEP);
  assign status.greater = acc1 > acc2;

endmodule

[hw/rtl/epsilon_greedy_arm_selector_top.sv]
// Top level of the epsilon-greedy arm selector: command FSM, config
// registers and result register. Depends on egas_pkg, egas_table, egas_cmp.
//
//   channel  | signals                          | transfer
//   ---------+----------------------------------+------------------------------
//   config   | cfg_we, cfg_index, cfg_data      | write at any edge with cfg_we
//   input    | start, busy, in_item             | beat when start && !busy
//   result   | done, out_item                   | one-cycle strobe on done
//
// Record: busy through table read and write-back. Explore choose: never busy,
// result the cycle after accept. Greedy choose: busy through a read and a load
// per arm, plus a 6-step shared multiplier compare per played arm beyond arm 0;
// done rises in the first cycle busy is low.
// Synchronous reset clears FSM, epsilon, table valid bits; active arms go to 16.
// Results cannot be stalled; done is high for exactly one cycle.
module epsilon_greedy_arm_selector_top #(
  parameter int NUM_ARMS   = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  egas_pkg::in_item_t              in_item,
  output logic                            done,
  output egas_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [egas_pkg::CFG_BITS-1:0]   cfg_data
);

  localparam int ARM_BITS = $clog2(NUM_ARMS);
  localparam int CW       = (ARM_BITS + 1 > egas_pkg::ACT_BITS) ? ARM_BITS + 1
                                                                : egas_pkg::ACT_BITS;
  localparam int SB       = egas_pkg::SUM_BITS;
  localparam int TW       = COUNT_BITS + SB;

  egas_pkg::state_t   state, state_next;
  egas_pkg::in_item_t item_q;

  logic [egas_pkg::EPS_BITS-1:0] epsilon_threshold;
  logic [egas_pkg::ACT_BITS-1:0] active_arms;

  logic [ARM_BITS-1:0]   scan_idx, best_idx, best_idx_next;
  logic signed [SB-1:0]  best_sum, cand_sum;
  logic [COUNT_BITS-1:0] best_cnt, cand_cnt;

  logic                  tbl_we;
  logic [ARM_BITS-1:0]   tbl_waddr, tbl_raddr;
  logic [TW-1:0]         tbl_wdata, tbl_rdata;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic signed [SB-1:0]  rd_sum;

  egas_pkg::cmp_status_t cmp_st;
  logic                  cmp_start;

  logic [CW-1:0] act, ra_ext;
  logic          accept, explore, arm_ok, scan_last, advance, take;

  // ---------------- storage ----------------
  egas_table #(
    .WIDTH(TW),
    .DEPTH(NUM_ARMS)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  egas_cmp #(
    .COUNT_BITS(COUNT_BITS)
  ) u_cmp (
    .clk   (clk),
    .rst   (rst),
    .start (cmp_start),
    .a     (rd_sum),
    .b     (rd_cnt),
    .c     (best_sum),
    .d     (best_cnt),
    .status(cmp_st)
  );

  assign rd_cnt = tbl_rdata[TW-1 -: COUNT_BITS];
  assign rd_sum = $signed(tbl_rdata[SB-1:0]);

  // ---------------- decode ----------------
  always_comb begin
    if (active_arms == '0) begin
      act = CW'(1);
    end else if (CW'(active_arms) > CW'(NUM_ARMS)) begin
      act = CW'(NUM_ARMS);
    end else begin
      act = CW'(active_arms);
    end
  end

  assign accept    = start && (state == egas_pkg::ST_IDLE);
  assign explore   = {1'b0, in_item.random_fraction} < epsilon_threshold;
  assign arm_ok    = CW'(in_item.arm_index) < CW'(NUM_ARMS);
  assign ra_ext    = (CW'(in_item.random_arm) >= act) ? act - CW'(1)
                                                      : CW'(in_item.random_arm);
  assign scan_last = (CW'(scan_idx) + CW'(1)) >= act;
  assign busy      = (state != egas_pkg::ST_IDLE);

  // ---------------- next state and table control ----------------
  always_comb begin
    state_next = state;
    tbl_raddr  = scan_idx;
    tbl_we     = 1'b0;
    tbl_waddr  = ARM_BITS'(item_q.arm_index);
    tbl_wdata  = {rd_cnt + COUNT_BITS'(1), rd_sum + SB'($signed(item_q.reward_value))};
    cmp_start  = 1'b0;
    advance    = 1'b0;
    take       = 1'b0;
    unique case (state)
      egas_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item.cmd == egas_pkg::CMD_RECORD) begin
            if (arm_ok) begin
              state_next = egas_pkg::ST_REC_RD;
            end
          end else if (!explore) begin
            state_next = egas_pkg::ST_CH_RD;
          end
        end
      end
      egas_pkg::ST_REC_RD: begin
        tbl_raddr  = ARM_BITS'(item_q.arm_index);
        state_next = egas_pkg::ST_REC_WR;
      end
      egas_pkg::ST_REC_WR: begin
        // saturated count: item dropped, sum untouched
        tbl_we     = (rd_cnt != '1);
        state_next = egas_pkg::ST_IDLE;
      end
      egas_pkg::ST_CH_RD: begin
        state_next = egas_pkg::ST_CH_LOAD;
      end
      egas_pkg::ST_CH_LOAD: begin
        if (scan_idx != '0 && rd_cnt != '0) begin
          cmp_start  = 1'b1;
          state_next = egas_pkg::ST_CH_CMP;
        end else begin
          advance = 1'b1;
        end
      end
      egas_pkg::ST_CH_CMP: begin
        if (cmp_st.done) begin
          advance = 1'b1;
          take    = cmp_st.greater;
        end
      end
      default: state_next = egas_pkg::ST_IDLE;
    endcase
    if (advance) begin
      state_next = scan_last ? egas_pkg::ST_IDLE : egas_pkg::ST_CH_RD;
    end
    best_idx_next = take ? scan_idx : best_idx;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= egas_pkg::ST_IDLE;
      done              <= 1'b0;
      epsilon_threshold <= '0;
      active_arms       <= egas_pkg::ACT_BITS'(16);
    end else begin
      state <= state_next;
      done  <= (accept && in_item.cmd == egas_pkg::CMD_CHOOSE && explore)
               || (advance && scan_last);
      if (cfg_we) begin
        unique case (cfg_index)
          egas_pkg::REG_EPSILON: epsilon_threshold <= cfg_data;
          egas_pkg::REG_ACTIVE:  active_arms <= cfg_data[egas_pkg::ACT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q   <= in_item;
      scan_idx <= '0;
      if (in_item.cmd == egas_pkg::CMD_CHOOSE && explore) begin
        out_item.chosen_arm <= ra_ext[3:0];
        out_item.explored   <= 1'b1;
      end
    end
    if (state == egas_pkg::ST_CH_LOAD) begin
      cand_sum <= rd_sum;
      cand_cnt <= rd_cnt;
      if (scan_idx == '0) begin
        // arm 0 is the default; unplayed means a mean of 0/1
        best_sum <= (rd_cnt != '0) ? rd_sum : '0;
        best_cnt <= (rd_cnt != '0) ? rd_cnt : COUNT_BITS'(1);
      end
    end
    if (take) begin
      best_sum <= cand_sum;
      best_cnt <= cand_cnt;
    end
    best_idx <= accept ? '0 : best_idx_next;
    if (advance) begin
      scan_idx <= scan_idx + ARM_BITS'(1);
      if (scan_last) begin
        out_item.chosen_arm <= 4'(best_idx_next);
        out_item.explored   <= 1'b0;
      end
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for epsilon_greedy_arm_selector_top: a directed table, then random
// record/choose traffic over several register settings, scored by an in-bench arm model.
// Depends on egas_pkg and the selector RTL.
module tb_top;
  import egas_pkg::*;

  localparam int ARMS        = 16;
  localparam int CNT_W       = 32;
  localparam int XW          = SUM_BITS + CNT_W + 2;  // cross-product width
  localparam int SETTLE      = 140;   // covers the worst greedy scan plus the result
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 130;

  typedef enum logic [1:0] {ROW_WRITE, ROW_BEAT, ROW_BEAT_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                reg_idx;
    logic [CFG_BITS-1:0] reg_val;
    in_item_t            beat;
    out_item_t           want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                done;
  out_item_t           out_item;
  logic                cfg_we;
  logic                cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  // mirror of the arm tables and registers
  logic [CNT_W-1:0]           plays [ARMS];
  logic signed [SUM_BITS-1:0] sums  [ARMS];
  logic [EPS_BITS-1:0]        eps_reg;
  logic [ACT_BITS-1:0]        act_reg;

  out_item_t picks_due [$];
  out_item_t due_pick;
  dir_row_t  plan [32];
  int        plan_n;
  int        fails;
  int        shown;
  int        stall_n;
  int        quiet_left;
  bit        quiet;

  epsilon_greedy_arm_selector_top #(.NUM_ARMS(ARMS), .COUNT_BITS(CNT_W)) uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // exact a/ca > b/cb by cross-multiplying, counts nonzero
  function automatic bit mean_above(logic signed [SUM_BITS-1:0] sa, logic [CNT_W-1:0] ca,
                                    logic signed [SUM_BITS-1:0] sb, logic [CNT_W-1:0] cb);
    logic signed [XW-1:0] lhs;
    logic signed [XW-1:0] rhs;
    lhs = XW'(sa) * XW'($signed({1'b0, cb}));
    rhs = XW'(sb) * XW'($signed({1'b0, ca}));
    return lhs > rhs;
  endfunction

  function automatic void log_reward(in_item_t it);
    // saturated count drops the whole beat
    if (plays[it.arm_index] != '1) begin
      plays[it.arm_index] = plays[it.arm_index] + CNT_W'(1);
      sums[it.arm_index]  = sums[it.arm_index] + SUM_BITS'($signed(it.reward_value));
    end
  endfunction

  function automatic out_item_t pick_arm(in_item_t it);
    out_item_t                  r;
    int                         n_act;
    int                         lead;
    logic signed [SUM_BITS-1:0] lead_sum;
    logic [CNT_W-1:0]           lead_cnt;
    if (act_reg == 0) n_act = 1;
    else if (act_reg > ARMS) n_act = ARMS;
    else n_act = int'(act_reg);
    if ({1'b0, it.random_fraction} < eps_reg) begin
      if (it.random_arm >= n_act) r.chosen_arm = 4'(n_act - 1);
      else r.chosen_arm = it.random_arm;
      r.explored = 1'b1;
      return r;
    end
    // arm 0 is the default, mean 0 while unplayed
    lead     = 0;
    lead_sum = '0;
    lead_cnt = CNT_W'(1);
    if (plays[0] != 0) begin
      lead_sum = sums[0];
      lead_cnt = plays[0];
    end
    for (int i = 1; i < n_act; i++) begin
      if (plays[i] != 0 && mean_above(sums[i], plays[i], lead_sum, lead_cnt)) begin
        lead     = i;
        lead_sum = sums[i];
        lead_cnt = plays[i];
      end
    end
    r.chosen_arm = 4'(lead);
    r.explored   = 1'b0;
    return r;
  endfunction

  function automatic int idle_gap();
    if (quiet_left == 0) begin
      quiet_left = $urandom_range(8, 40);
      quiet      = ($urandom_range(0, 2) == 0);
    end
    quiet_left = quiet_left - 1;
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void t_reg(logic idx, int val);
    dir_row_t r;
    r         = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = CFG_BITS'(val);
    plan[plan_n] = r;
    plan_n       = plan_n + 1;
  endfunction

  function automatic void t_beat(logic c, int arm, int rew, int frac, int rarm);
    dir_row_t r;
    r                      = '0;
    r.kind                 = ROW_BEAT;
    r.beat.cmd             = c;
    r.beat.arm_index       = 4'(arm);
    r.beat.reward_value    = 16'(rew);
    r.beat.random_fraction = 16'(frac);
    r.beat.random_arm      = 4'(rarm);
    plan[plan_n] = r;
    plan_n       = plan_n + 1;
  endfunction

  function automatic void t_known(int frac, int rarm, int want_arm, bit want_expl);
    t_beat(CMD_CHOOSE, 0, 0, frac, rarm);
    plan[plan_n-1].kind            = ROW_BEAT_KNOWN;
    plan[plan_n-1].want.chosen_arm = 4'(want_arm);
    plan[plan_n-1].want.explored   = want_expl;
  endfunction

  task automatic send_beat(in_item_t it, bit known, out_item_t want);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (it.cmd == CMD_RECORD) log_reward(it);
    else if (known) picks_due.push_back(want);
    else picks_due.push_back(pick_arm(it));
  endtask

  // block idle: no pick pending and any record write-back finished
  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_BITS'(val);
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == REG_EPSILON) eps_reg = EPS_BITS'(val);
    else act_reg = ACT_BITS'(val);
  endtask

  function automatic void note_fail(string what, out_item_t want);
    fails = fails + 1;
    if (shown < 10) begin
      shown = shown + 1;
      $display("%0t: %s: expected arm %0d explored %0b, got arm %0d explored %0b", $time,
               what, want.chosen_arm, want.explored, out_item.chosen_arm, out_item.explored);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (picks_due.size() == 0) begin
        note_fail("unexpected pick", '0);
      end else begin
        due_pick = picks_due.pop_front();
        if (out_item.chosen_arm !== due_pick.chosen_arm ||
            out_item.explored !== due_pick.explored)
          note_fail("pick mismatch", due_pick);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_n = 0;
    end else begin
      stall_n = stall_n + 1;
      if (stall_n >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    int       e;
    int       a;
    int       style;
    int       k;
    rst       = 1'b1;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_EPSILON;
    cfg_data  = '0;
    eps_reg   = '0;
    act_reg   = ACT_BITS'(ARMS);
    for (int i = 0; i < ARMS; i++) begin
      plays[i] = '0;
      sums[i]  = '0;
    end

    plan_n = 0;
    t_known(16'h0000, 0, 0, 0);                // empty tables: default arm
    t_known(16'hFFFF, 15, 0, 0);
    t_beat(CMD_RECORD, 15, 32767, 0, 0);       // largest reward
    t_beat(CMD_RECORD, 0, -32768, 0, 0);       // smallest reward on the default arm
    t_beat(CMD_CHOOSE, 0, 0, 16'h0000, 0);
    t_beat(CMD_RECORD, 5, 32767, 0, 0);
    t_beat(CMD_CHOOSE, 0, 0, 16'h8000, 7);     // equal means, lower index wins
    t_beat(CMD_RECORD, 9, 0, 0, 0);
    t_reg(REG_ACTIVE, 0);                      // zero arms treated as one
    t_known(16'h0000, 9, 0, 0);
    t_reg(REG_EPSILON, 65536);                 // always explore
    t_known(16'hFFFF, 15, 0, 1);
    t_reg(REG_ACTIVE, 31);                     // clamps to the table size
    t_known(16'h0000, 15, 15, 1);
    t_reg(REG_ACTIVE, 5);
    t_known(16'h1234, 9, 4, 1);                // random arm clamped to last active
    t_reg(REG_EPSILON, 1);
    t_known(16'h0000, 3, 3, 1);
    t_beat(CMD_CHOOSE, 0, 0, 16'h0001, 3);     // fraction equal to threshold: greedy
    t_reg(REG_EPSILON, 17'h1FFFF);
    t_known(16'hFFFF, 0, 0, 1);
    t_reg(REG_EPSILON, 0);
    t_reg(REG_ACTIVE, 16);
    t_beat(CMD_RECORD, 3, -1, 0, 0);
    t_beat(CMD_CHOOSE, 0, 0, 16'hFFFF, 15);

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < plan_n; r++) begin
      if (plan[r].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[r].reg_idx, int'(plan[r].reg_val));
      end else begin
        send_beat(plan[r].beat, plan[r].kind == ROW_BEAT_KNOWN, plan[r].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin e = 0;      a = 16; end
        1: begin e = 65536;  a = 16; end
        2: begin e = 32768;  a = 7;  end
        3: begin e = 0;      a = 1;  end
        4: begin e = 1;      a = 31; end
        5: begin e = 131071; a = 0;  end
        6: begin e = 65535;  a = 2;  end
        default: begin
          e = $urandom_range(0, 131071);
          a = $urandom_range(0, 31);
        end
      endcase
      drain();
      write_reg(REG_EPSILON, e);
      write_reg(REG_ACTIVE, a);
      style = ph % 3;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        it.cmd       = ($urandom_range(0, 9) < 4) ? CMD_CHOOSE : CMD_RECORD;
        it.arm_index = 4'($urandom_range(0, 15));
        case (style)
          0: it.reward_value = 16'($urandom);
          1: begin
            k = $urandom_range(0, 3);
            it.reward_value = 16'(256 * (k - 1));     // coarse values make mean ties common
          end
          default: begin
            k = $urandom_range(0, 127);
            it.reward_value = 16'(int'(it.arm_index) * 64 - 512 + k);
          end
        endcase
        it.random_fraction = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(0, 2);
          k = e - 1 + k;
          if (k < 0) k = 0;
          if (k > 65535) k = 65535;
          it.random_fraction = 16'(k);
        end
        it.random_arm = 4'($urandom_range(0, 15));
        send_beat(it, 1'b0, '0);
      end
    end

    drain();
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
